### sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dda_pkg.sv
// shared types and constants for the ray setup pipeline
// no dependencies
`default_nettype none
package dda_pkg;

   // default map cell size in pixels
   localparam int CELL_SIZE_DEF = 64;

   // quarter turn in binary angle units, Q2.14 one
   localparam int unsigned QUARTER = 16384;

   // sine polynomial coefficients
   localparam int unsigned POLY_A = 51472;
   localparam int unsigned POLY_B = 21024;
   localparam int unsigned POLY_C = 2320;

   // reciprocal: quotient width, dividend bit position, stage split
   localparam int RECIP_QW     = 32;
   localparam int RECIP_ONE    = 30;
   localparam int RECIP_BPS    = 2;
   localparam int RECIP_STAGES = RECIP_QW / RECIP_BPS;

   // pipeline latencies in register stages
   localparam int TRIG_LAT  = 5;
   localparam int CELL_LAT  = 6;
   localparam int TOTAL_LAT = TRIG_LAT + RECIP_STAGES + 1;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] ray_angle;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
   } dda_req_type;

   typedef struct packed {
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
      logic [9:0]         cell_x;
      logic [9:0]         cell_y;
      logic               step_neg_x;
      logic               step_neg_y;
      logic [31:0]        delta_dist_x;
      logic [31:0]        delta_dist_y;
      logic [31:0]        side_dist_x;
      logic [31:0]        side_dist_y;
   } dda_rsp_type;

endpackage
`default_nettype wire

### sv/dda_ray_setup_core.sv
// an accepted request passes the trig stages, the reciprocal divider stages and the output register
// throughput: one transaction per cycle while responses are taken; the 16-stage reciprocal divider sets the depth
// a stalled response holds the whole pipeline, nothing is dropped or repeated
// reset: synchronous, active high, clears the valid bits only
// depends on dda_pkg, dda_trig, dda_recip, dda_cell
`default_nettype none
module dda_ray_setup_core import dda_pkg::*; #(
   parameter int CELL_SIZE = CELL_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dda_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output dda_rsp_type      rsp_data
);

   localparam int POS_DLY = TRIG_LAT + RECIP_STAGES - CELL_LAT;

   logic               en;
   logic               vld_ff [TOTAL_LAT];
   logic signed [15:0] cos_w;
   logic signed [15:0] sin_w;
   logic [14:0]        mag_x;
   logic [14:0]        mag_y;
   logic [31:0]        quo_x;
   logic [31:0]        quo_y;
   logic [9:0]         cell_x_w;
   logic [9:0]         cell_y_w;
   logic [15:0]        frac_x_w;
   logic [15:0]        frac_y_w;
   logic signed [15:0] cos_dly_ff [RECIP_STAGES];
   logic signed [15:0] sin_dly_ff [RECIP_STAGES];
   logic [9:0]         cx_dly_ff  [POS_DLY];
   logic [9:0]         cy_dly_ff  [POS_DLY];
   logic [15:0]        fx_dly_ff  [POS_DLY];
   logic [15:0]        fy_dly_ff  [POS_DLY];
   dda_rsp_type        out_in;
   dda_rsp_type        out_ff;

   // global advance: move when the output slot is empty or taken
   assign en        = !vld_ff[TOTAL_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOTAL_LAT-1];
   assign rsp_data  = out_ff;

   dda_trig u_trig (
      .clock   (clock),
      .en      (en),
      .angle   (req_data.ray_angle),
      .dir_cos (cos_w),
      .dir_sin (sin_w)
   );

   // magnitudes for the reciprocal
   assign mag_x = cos_w[15] ? 15'(-cos_w) : cos_w[14:0];
   assign mag_y = sin_w[15] ? 15'(-sin_w) : sin_w[14:0];

   dda_recip u_recip_x (.clock(clock), .en(en), .mag(mag_x), .quo(quo_x));
   dda_recip u_recip_y (.clock(clock), .en(en), .mag(mag_y), .quo(quo_y));

   dda_cell #(.CELL_SIZE(CELL_SIZE)) u_cell_x (
      .clock (clock), .en (en), .pos (req_data.pos_x), .cell_idx (cell_x_w), .frac (frac_x_w)
   );
   dda_cell #(.CELL_SIZE(CELL_SIZE)) u_cell_y (
      .clock (clock), .en (en), .pos (req_data.pos_y), .cell_idx (cell_y_w), .frac (frac_y_w)
   );

   // side distance, saturation and response assembly
   always_comb begin
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic [16:0]        fx;
      logic [16:0]        fy;
      c  = cos_dly_ff[RECIP_STAGES-1];
      s  = sin_dly_ff[RECIP_STAGES-1];
      fx = c[15] ? {1'b0, fx_dly_ff[POS_DLY-1]} : 17'h10000 - {1'b0, fx_dly_ff[POS_DLY-1]};
      fy = s[15] ? {1'b0, fy_dly_ff[POS_DLY-1]} : 17'h10000 - {1'b0, fy_dly_ff[POS_DLY-1]};
      out_in.dir_cos      = c;
      out_in.dir_sin      = s;
      out_in.cell_x       = cx_dly_ff[POS_DLY-1];
      out_in.cell_y       = cy_dly_ff[POS_DLY-1];
      out_in.step_neg_x   = c[15];
      out_in.step_neg_y   = s[15];
      out_in.delta_dist_x = (c == 16'sd0) ? SAT32 : quo_x;
      out_in.delta_dist_y = (s == 16'sd0) ? SAT32 : quo_y;
      out_in.side_dist_x  = (c == 16'sd0) ? SAT32 : 32'((49'(fx) * 49'(quo_x)) >> 16);
      out_in.side_dist_y  = (s == 16'sd0) ? SAT32 : 32'((49'(fy) * 49'(quo_y)) >> 16);
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL_LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // alignment delay lines and output register
   always_ff @(posedge clock) begin
      if (en) begin
         cos_dly_ff[0] <= cos_w;
         sin_dly_ff[0] <= sin_w;
         for (int i = 1; i < RECIP_STAGES; i++) begin
            cos_dly_ff[i] <= cos_dly_ff[i-1];
            sin_dly_ff[i] <= sin_dly_ff[i-1];
         end
         cx_dly_ff[0] <= cell_x_w;
         cy_dly_ff[0] <= cell_y_w;
         fx_dly_ff[0] <= frac_x_w;
         fy_dly_ff[0] <= frac_y_w;
         for (int i = 1; i < POS_DLY; i++) begin
            cx_dly_ff[i] <= cx_dly_ff[i-1];
            cy_dly_ff[i] <= cy_dly_ff[i-1];
            fx_dly_ff[i] <= fx_dly_ff[i-1];
            fy_dly_ff[i] <= fy_dly_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

### sv/dda_trig.sv
// five stage polynomial sine and cosine of a binary angle, Q2.14 out
// depends on dda_pkg
`default_nettype none
module dda_trig import dda_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [15:0]        angle,
   output logic signed [15:0]      dir_cos,
   output logic signed [15:0]      dir_sin
);

   // lane 0 is cosine, lane 1 is sine
   logic [14:0] t1_ff  [2];
   logic        n1_ff  [2];
   logic [14:0] z2_ff  [2];
   logic [14:0] t2_ff  [2];
   logic        n2_ff  [2];
   logic [14:0] z3_ff  [2];
   logic [14:0] z2b_ff [2];
   logic [14:0] t3_ff  [2];
   logic        n3_ff  [2];
   logic [14:0] z5_ff  [2];
   logic [29:0] at_ff  [2];
   logic [28:0] bz_ff  [2];
   logic        n4_ff  [2];
   logic signed [15:0] res_ff [2];

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [15:0] a_in;
      logic [14:0] t_in;
      logic [29:0] z2_full;
      logic [29:0] z3_full;
      logic [29:0] z5_full;
      logic [31:0] pos_sum;
      logic [31:0] diff;
      logic [16:0] s_raw;
      logic [14:0] s_mag;
      logic signed [15:0] res_in;

      // quadrant fold
      always_comb begin
         a_in = (l == 0) ? angle + 16'(QUARTER) : angle;
         t_in = a_in[14] ? 15'(QUARTER) - {1'b0, a_in[13:0]} : {1'b0, a_in[13:0]};
      end

      // powers of z, one multiply per stage
      assign z2_full = t1_ff[l] * t1_ff[l];
      assign z3_full = z2_ff[l] * t2_ff[l];
      assign z5_full = z3_ff[l] * z2b_ff[l];

      // polynomial sum, clamp and sign
      always_comb begin
         pos_sum = 32'(at_ff[l]) + 32'(POLY_C) * 32'(z5_ff[l]) + 32'(QUARTER);
         diff    = pos_sum - 32'(bz_ff[l]);
         s_raw   = 17'(diff >> 15);
         if (32'(bz_ff[l]) >= pos_sum) begin
            s_mag = '0;
         end else if (s_raw > 17'(QUARTER)) begin
            s_mag = 15'(QUARTER);
         end else begin
            s_mag = s_raw[14:0];
         end
         res_in = n4_ff[l] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            t1_ff[l]  <= t_in;
            n1_ff[l]  <= a_in[15];
            z2_ff[l]  <= 15'(z2_full >> 14);
            t2_ff[l]  <= t1_ff[l];
            n2_ff[l]  <= n1_ff[l];
            z3_ff[l]  <= 15'(z3_full >> 14);
            z2b_ff[l] <= z2_ff[l];
            t3_ff[l]  <= t2_ff[l];
            n3_ff[l]  <= n2_ff[l];
            z5_ff[l]  <= 15'(z5_full >> 14);
            at_ff[l]  <= 30'(32'(POLY_A) * 32'(t3_ff[l]));
            bz_ff[l]  <= 29'(32'(POLY_B) * 32'(z3_ff[l]));
            n4_ff[l]  <= n3_ff[l];
            res_ff[l] <= res_in;
         end
      end
   end

   assign dir_cos = res_ff[0];
   assign dir_sin = res_ff[1];

endmodule
`default_nettype wire

### sv/dda_recip.sv
// pipelined restoring divider for 2^30 / mag, two quotient bits per stage
// depends on dda_pkg
`default_nettype none
module dda_recip import dda_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [14:0]          mag,
   output logic [RECIP_QW-1:0]       quo
);

   logic [14:0]          rem_ff [RECIP_STAGES];
   logic [RECIP_QW-1:0]  quo_ff [RECIP_STAGES];
   logic [14:0]          mag_ff [RECIP_STAGES];

   for (genvar g = 0; g < RECIP_STAGES; g++) begin : g_stage
      logic [14:0]         rem_prev;
      logic [RECIP_QW-1:0] quo_prev;
      logic [14:0]         mag_prev;
      logic [15:0]         r2;
      logic [14:0]         rem_in;
      logic [RECIP_QW-1:0] quo_in;

      if (g == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign mag_prev = mag;
      end else begin : g_next
         assign rem_prev = rem_ff[g-1];
         assign quo_prev = quo_ff[g-1];
         assign mag_prev = mag_ff[g-1];
      end

      // shift in each of the stage's dividend bits, compare and subtract
      always_comb begin
         rem_in = rem_prev;
         quo_in = quo_prev;
         r2     = '0;
         for (int j = 0; j < RECIP_BPS; j++) begin
            r2 = {rem_in, ((RECIP_QW - 1 - g * RECIP_BPS - j) == RECIP_ONE)};
            if (r2 >= {1'b0, mag_prev}) begin
               r2 = r2 - {1'b0, mag_prev};
               quo_in[RECIP_QW - 1 - g * RECIP_BPS - j] = 1'b1;
            end
            rem_in = r2[14:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            mag_ff[g] <= mag_prev;
         end
      end
   end

   assign quo = quo_ff[RECIP_STAGES-1];

endmodule
`default_nettype wire

### sv/dda_cell.sv
// map cell index and cell offset by constant division, six stages
// depends on dda_pkg
`default_nettype none
module dda_cell import dda_pkg::*; #(
   parameter int CELL_SIZE = CELL_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [23:0] pos,
   output logic [9:0]       cell_idx,
   output logic [15:0]      frac
);

   localparam int L   = $clog2(CELL_SIZE);
   localparam int RW  = $clog2(CELL_SIZE + 1);
   localparam int NW2 = RW + 16;
   localparam int S1  = 16 + L;
   localparam int S2  = NW2 + L;
   localparam logic [63:0] M1_FULL = (64'd1 << S1) / CELL_SIZE;
   localparam logic [63:0] M2_FULL = (64'd1 << S2) / CELL_SIZE;
   localparam logic [16:0]    M1 = M1_FULL[16:0];
   localparam logic [NW2:0]   M2 = M2_FULL[NW2:0];
   localparam logic [RW:0]    CS = (RW + 1)'(CELL_SIZE);

   logic [33:0]        prod1_ff;
   logic [15:0]        hi_keep_ff;
   logic [7:0]         lo1_ff;
   logic [15:0]        q1_ff;
   logic [RW:0]        r1_ff;
   logic [7:0]         lo2_ff;
   logic [9:0]         cell3_ff;
   logic [NW2-1:0]     num_ff;
   logic [9:0]         cell4_ff;
   logic [2*NW2:0]     prod2_ff;
   logic [NW2-1:0]     num4_ff;
   logic [9:0]         cell5_ff;
   logic [15:0]        q2_ff;
   logic [RW:0]        r2_ff;
   logic [9:0]         cell6_ff;
   logic [15:0]        frac_ff;

   logic [15:0]        q1_in;
   logic [RW:0]        r1_in;
   logic [15:0]        q1c;
   logic [RW-1:0]      r1c;
   logic [15:0]        q2_in;
   logic [RW:0]        r2_in;

   // estimate quotient of whole pixels, remainder of estimate
   always_comb begin
      q1_in = 16'(prod1_ff >> S1);
      r1_in = (RW + 1)'(32'(hi_keep_ff) - 32'(q1_in) * 32'(CELL_SIZE));
   end

   // one correction step
   always_comb begin
      if (r1_ff >= CS) begin
         q1c = q1_ff + 16'd1;
         r1c = RW'(r1_ff - CS);
      end else begin
         q1c = q1_ff;
         r1c = RW'(r1_ff);
      end
   end

   // offset quotient estimate and remainder
   always_comb begin
      q2_in = 16'(prod2_ff >> S2);
      r2_in = (RW + 1)'(64'(num4_ff) - 64'(q2_in) * 64'(CELL_SIZE));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff   <= 34'(pos[23:8] * M1);
         hi_keep_ff <= pos[23:8];
         lo1_ff     <= pos[7:0];
         q1_ff      <= q1_in;
         r1_ff      <= r1_in;
         lo2_ff     <= lo1_ff;
         cell3_ff   <= q1c[9:0];
         num_ff     <= {r1c, lo2_ff, 8'd0};
         cell4_ff   <= cell3_ff;
         prod2_ff   <= (2 * NW2 + 1)'(num_ff * M2);
         num4_ff    <= num_ff;
         cell5_ff   <= cell4_ff;
         q2_ff      <= q2_in;
         r2_ff      <= r2_in;
         cell6_ff   <= cell5_ff;
         frac_ff    <= (r2_ff >= CS) ? q2_ff + 16'd1 : q2_ff;
      end
   end

   assign cell_idx = cell6_ff;
   assign frac     = frac_ff;

endmodule
`default_nettype wire

### sv/dda_checker.sv
// port-level checks for the ray setup core, bound to the top level
// depends on dda_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module dda_checker import dda_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire dda_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire dda_rsp_type rsp_data
);

   // a stalled response holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")

   // x step sign follows the cosine sign
   `ASSERT_CLK(a_step_x, clock, reset, rsp_valid |-> rsp_data.step_neg_x == rsp_data.dir_cos[15], "step x disagrees with cosine")

   // zero sine saturates both y distances
   `ASSERT_CLK(a_sat_y, clock, reset, rsp_valid && rsp_data.dir_sin == 16'sd0 |-> rsp_data.delta_dist_y == SAT32 && rsp_data.side_dist_y == SAT32, "zero sine not saturated")

   // reset empties the pipeline
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind dda_ray_setup_core dda_checker u_dda_checker (.*);
`default_nettype wire

### verif/dda_ray_checker.sv
// checker for the ray setup core: predicts each response from the accepted request
// depends on dda_pkg
`timescale 1ns / 1ps
module dda_ray_checker import dda_pkg::*; #(
   parameter int CELL_SIZE = CELL_SIZE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire dda_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire dda_rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);

   dda_rsp_type rays_due[$];

   // polynomial sine over one quarter turn, Q14
   function automatic logic [31:0] quarter_sin(input logic [31:0] t);
      logic [63:0] z2, z3, z5, up, dn, s;
      z2 = (64'(t) * t) >> 14;
      z3 = (z2 * t) >> 14;
      z5 = (z3 * z2) >> 14;
      up = 64'(POLY_A) * t + 64'(POLY_C) * z5 + 64'd16384;
      dn = 64'(POLY_B) * z3;
      if (dn >= up) return 0;
      s = (up - dn) >> 15;
      if (s > QUARTER) s = QUARTER;
      return s[31:0];
   endfunction

   function automatic logic signed [15:0] angle_sin(input logic [15:0] a);
      logic [31:0] s;
      s = a[14] ? quarter_sin(QUARTER - a[13:0]) : quarter_sin(a[13:0]);
      return a[15] ? -$signed(s[15:0]) : $signed(s[15:0]);
   endfunction

   // per-axis cell, step, delta and side distance
   function automatic void axis_calc(input logic signed [15:0] dir, input logic [23:0] pos,
                                     output logic [9:0] cell_idx, output logic neg,
                                     output logic [31:0] delta, output logic [31:0] side);
      logic [63:0] span, frac, mag, d, sd;
      span = 64'(CELL_SIZE) * 256;
      frac = ((64'(pos) % span) << 16) / span;
      mag  = dir < 0 ? 64'(-32'(dir)) : 64'(dir);
      cell_idx = 10'((64'(pos) / span));
      neg  = dir < 0;
      if (mag == 0) begin
         delta = SAT32;
         side  = SAT32;
      end else begin
         d  = (64'd1 << 30) / mag;
         sd = dir < 0 ? (frac * d) >> 16 : (((64'd1 << 16) - frac) * d) >> 16;
         delta = d[31:0];
         side  = sd > SAT32 ? SAT32 : sd[31:0];
      end
   endfunction

   function automatic dda_rsp_type predict_ray(input dda_req_type r);
      dda_rsp_type e;
      e.dir_cos = angle_sin(r.ray_angle + 16'(QUARTER));
      e.dir_sin = angle_sin(r.ray_angle);
      axis_calc(e.dir_cos, r.pos_x, e.cell_x, e.step_neg_x, e.delta_dist_x, e.side_dist_x);
      axis_calc(e.dir_sin, r.pos_y, e.cell_y, e.step_neg_y, e.delta_dist_y, e.side_dist_y);
      return e;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = rays_due.size();

   initial fail_count = 0;

   // queue expectations and compare responses
   always @(posedge clock) begin
      dda_rsp_type w;
      if (!reset) begin
         if (req_valid && req_ready) rays_due.push_back(predict_ray(req_data));
         if (rsp_valid && rsp_ready) begin
            if (rays_due.size() == 0) begin
               report_mismatch("unexpected transaction", 0, 0);
            end else begin
               w = rays_due.pop_front();
               if (rsp_data.dir_cos !== w.dir_cos)
                  report_mismatch("dir_cos", 32'(rsp_data.dir_cos), 32'(w.dir_cos));
               if (rsp_data.dir_sin !== w.dir_sin)
                  report_mismatch("dir_sin", 32'(rsp_data.dir_sin), 32'(w.dir_sin));
               if (rsp_data.cell_x !== w.cell_x)
                  report_mismatch("cell_x", 32'(rsp_data.cell_x), 32'(w.cell_x));
               if (rsp_data.cell_y !== w.cell_y)
                  report_mismatch("cell_y", 32'(rsp_data.cell_y), 32'(w.cell_y));
               if (rsp_data.step_neg_x !== w.step_neg_x)
                  report_mismatch("step_neg_x", 32'(rsp_data.step_neg_x), 32'(w.step_neg_x));
               if (rsp_data.step_neg_y !== w.step_neg_y)
                  report_mismatch("step_neg_y", 32'(rsp_data.step_neg_y), 32'(w.step_neg_y));
               if (rsp_data.delta_dist_x !== w.delta_dist_x)
                  report_mismatch("delta_dist_x", rsp_data.delta_dist_x, w.delta_dist_x);
               if (rsp_data.delta_dist_y !== w.delta_dist_y)
                  report_mismatch("delta_dist_y", rsp_data.delta_dist_y, w.delta_dist_y);
               if (rsp_data.side_dist_x !== w.side_dist_x)
                  report_mismatch("side_dist_x", rsp_data.side_dist_x, w.side_dist_x);
               if (rsp_data.side_dist_y !== w.side_dist_y)
                  report_mismatch("side_dist_y", rsp_data.side_dist_y, w.side_dist_y);
            end
         end
      end
   end

endmodule

### verif/tb_top.sv
// top of the ray setup testbench: clock, reset, stimulus and verdict
// depends on dda_pkg, dda_ray_setup_core and dda_ray_checker
`timescale 1ns / 1ps
module tb_top;
   import dda_pkg::*;

   localparam int RAND_RAYS = 400;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   dda_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   dda_rsp_type rsp_data;
   int          fail_count, pending_count;
   int          cycle_count = 0;
   bit          hold_off = 0;

   dda_ray_setup_core dut (.*);
   dda_ray_checker chk (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // offer one transaction after a random gap, return once it is taken
   task automatic send_ray(input logic [15:0] ang, input logic [23:0] px,
                           input logic [23:0] py);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 1)) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= '{ray_angle: ang, pos_x: px, pos_y: py};
      do @(posedge clock); while (!req_ready);
   endtask

   // random position, biased toward cell edges now and then
   function automatic logic [23:0] rand_pos();
      logic [23:0] p;
      p = 24'($urandom);
      case ($urandom_range(0, 3))
         0: p[13:0] = 0;
         1: p[13:0] = 14'h3FFF;
         default: ;
      endcase
      return p;
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            @(posedge clock);
         end else begin
            wait_cycles = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
            if (wait_cycles > 0) begin
               rsp_ready <= 0;
               repeat (wait_cycles) @(posedge clock);
            end
            rsp_ready <= 1;
            do @(posedge clock); while (!rsp_valid);
         end
      end
   end

   // long hold-off counted in cycles
   initial begin
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_off = 1;
      repeat (120) @(posedge clock);
      hold_off = 0;
   end

   // stimulus
   initial begin
      logic [15:0] ang;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // quarter turns, extremes and cell edges
      send_ray(16'h0000, 24'h000000, 24'h000000);
      send_ray(16'h4000, 24'hFFFFFF, 24'hFFFFFF);
      send_ray(16'h8000, 24'h004000, 24'h003FFF);
      send_ray(16'hC000, 24'h000000, 24'h004000);
      send_ray(16'hFFFF, 24'hFFFFFF, 24'h000000);
      send_ray(16'h0001, 24'h123456, 24'h654321);
      send_ray(16'h3FFF, 24'h004000, 24'h004000);
      send_ray(16'h4001, 24'h000000, 24'hFFFFFF);
      send_ray(16'h7FFF, 24'h008000, 24'h00C000);
      send_ray(16'h8001, 24'h000001, 24'h000001);
      send_ray(16'hBFFF, 24'h004000, 24'h000000);
      send_ray(16'hC001, 24'hAAAAAA, 24'h555555);
      send_ray(16'h2000, 24'h002000, 24'h002000);
      send_ray(16'hA000, 24'h000000, 24'h000000);
      send_ray(16'h6000, 24'hFFC000, 24'hFFC000);
      send_ray(16'hE000, 24'h003FFF, 24'hFFFFFF);
      for (int i = 0; i < RAND_RAYS; i++) begin
         ang = 16'($urandom);
         if ($urandom_range(0, 7) == 0) ang = 16'($urandom_range(0, 3)) << 14;
         else if ($urandom_range(0, 7) == 0) ang = ang ^ 16'($urandom_range(0, 3));
         send_ray(ang, rand_pos(), rand_pos());
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TOTAL_LAT + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
